>>> design/http_request_header_parser_core_assert.svh
// Assertion macros used by the parser core RTL.
`ifndef HTTP_REQUEST_HEADER_PARSER_CORE_ASSERT_SVH
`define HTTP_REQUEST_HEADER_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HRHP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parser assertion failed");

// Next-cycle implication, checked outside reset.
`define HRHP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("parser assertion failed");

`endif

>>> design/hrhp_pkg.sv
package hrhp_pkg;

    localparam int MAX_HEADERS = 32;
    localparam int LEN_W       = 24;
    localparam int HDR_CNT_W   = $clog2(MAX_HEADERS + 1);
    localparam int HNUM_W      = 5;
    localparam int NAME_LEN    = 14;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam logic [7:0] CH_SP    = " ";
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_H     = "H";
    localparam logic [7:0] CH_T     = "T";
    localparam logic [7:0] CH_P     = "P";
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_COLON = ":";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_ZERO  = "0";

    typedef enum logic [1:0] {
        ST_MORE, ST_COMPLETE, ST_MALFORMED
    } t_status;

    typedef enum logic [2:0] {
        KIND_DELIM, KIND_METHOD, KIND_URI, KIND_HNAME, KIND_HVALUE, KIND_BODY
    } t_kind;

    // Content-Length value phase
    typedef enum logic [2:0] {
        LF_NONE, LF_LEAD, LF_PLUS, LF_DIGITS, LF_DONE, LF_BAD
    } t_len_phase;

    typedef enum logic [2:0] {
        LOP_NONE, LOP_NAME_FIRST, LOP_NAME_BYTE, LOP_COLON, LOP_VALUE
    } t_len_op;

    typedef struct packed {
        logic       is_token;
        logic       is_ctl;
        logic       is_dec;
        logic [3:0] digit;
        logic       is_sp;
        logic       is_tab;
        logic       is_cr;
        logic       is_lf;
        logic       is_plus;
    } t_byte_class;

    typedef struct packed {
        logic [3:0]       pos;
        logic             still;
        t_len_phase       phase;
        logic [LEN_W-1:0] acc;
    } t_len_ctx;

    function automatic logic [7:0] name_char(input logic [3:0] pos);
        case (pos)
            4'd0:    return "C";
            4'd1:    return "o";
            4'd2:    return "n";
            4'd3:    return "t";
            4'd4:    return "e";
            4'd5:    return "n";
            4'd6:    return "t";
            4'd7:    return "-";
            4'd8:    return "L";
            4'd9:    return "e";
            4'd10:   return "n";
            4'd11:   return "g";
            4'd12:   return "t";
            4'd13:   return "h";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] dec_acc_len(input logic [LEN_W-1:0] acc,
                                                     input logic [3:0] d);
        logic [LEN_W+3:0] v;
        v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (LEN_W+4)'(d);
        return (v > (LEN_W+4)'(LEN_MAX)) ? LEN_MAX : v[LEN_W-1:0];
    endfunction

    function automatic logic [7:0] dec_acc_ver(input logic [7:0] acc, input logic [3:0] d);
        logic [11:0] v;
        v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 12'(d);
        return (v > 12'd255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [LEN_W-1:0] eff_length(input t_len_ctx c);
        return (c.phase == LF_DIGITS || c.phase == LF_DONE) ? c.acc : '0;
    endfunction

endpackage

>>> design/hrhp_if.sv
interface hrhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source(output valid, output data_byte, output restart, input ready);
    modport sink(input valid, input data_byte, input restart, output ready);
endinterface

interface hrhp_out_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [2:0]               byte_kind;
    logic [7:0]               byte_out;
    logic [4:0]               header_number;
    logic [7:0]               version_major;
    logic [7:0]               version_minor;
    logic [hrhp_pkg::LEN_W-1:0] body_length;

    modport source(output valid, output status, output byte_kind, output byte_out,
                   output header_number, output version_major, output version_minor,
                   output body_length, input ready);
    modport sink(input valid, input status, input byte_kind, input byte_out,
                 input header_number, input version_major, input version_minor,
                 input body_length, output ready);
endinterface

>>> design/http_request_header_parser_core.sv
// A byte goes into the input register, its result into the result register, held
// while the output stalls. Throughput: one byte per cycle unless the output stalls;
// the parser update (state, name match, decimal accumulate) is combinational between
// them. Reset: i_rst_n is synchronous, active low; it empties both stages and returns
// the parser to method start. A restart byte returns it there before it is parsed.
`include "http_request_header_parser_core_assert.svh"

module http_request_header_parser_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hrhp_in_if.sink         i_in,
    hrhp_out_if.source      o_out
);
    typedef enum logic [4:0] {
        S_METHOD_START, S_METHOD, S_URI, S_VH, S_VT1, S_VT2, S_VP, S_VSLASH,
        S_MAJ_START, S_MAJ, S_MIN_START, S_MIN, S_NL1, S_LINE_START, S_LWS,
        S_NAME, S_SP_VALUE, S_VALUE, S_NL2, S_NL3, S_BODY
    } t_state;

    // input stage
    logic                           r_in_vld;
    logic [7:0]                     r_in_byte;
    logic                           r_in_restart;

    // parser state
    t_state                         r_state, c_state, n_state;
    logic                           r_hdr_seen, c_hdr_seen, n_hdr_seen;
    logic [hrhp_pkg::HDR_CNT_W-1:0] r_hdr_cnt, c_hdr_cnt, n_hdr_cnt;
    hrhp_pkg::t_len_ctx             r_len, c_len, n_len;
    logic [hrhp_pkg::LEN_W-1:0]     r_body_cnt, c_body_cnt, n_body_cnt;
    logic [7:0]                     r_major, c_major, n_major;
    logic [7:0]                     r_minor, c_minor, n_minor;

    // result stage
    logic                           r_out_vld;
    hrhp_pkg::t_status              r_status, n_status;
    hrhp_pkg::t_kind                r_kind, n_kind;
    logic [7:0]                     r_byte_out;
    logic [4:0]                     r_hnum, n_hnum;
    logic [hrhp_pkg::LEN_W-1:0]     r_length;

    logic                           w_step;
    logic                           w_bad;
    hrhp_pkg::t_len_op              w_len_op;
    hrhp_pkg::t_byte_class          w_cls;
    logic [hrhp_pkg::HDR_CNT_W-1:0] w_hdr_dec;

    assign w_step   = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_step;

    // restart applies before the byte is judged
    always_comb begin
        if (r_in_restart) begin
            c_state    = S_METHOD_START;
            c_hdr_seen = 1'b0;
            c_hdr_cnt  = '0;
            c_len      = '{pos: 4'd0, still: 1'b0, phase: hrhp_pkg::LF_NONE, acc: '0};
            c_body_cnt = '0;
            c_major    = '0;
            c_minor    = '0;
        end else begin
            c_state    = r_state;
            c_hdr_seen = r_hdr_seen;
            c_hdr_cnt  = r_hdr_cnt;
            c_len      = r_len;
            c_body_cnt = r_body_cnt;
            c_major    = r_major;
            c_minor    = r_minor;
        end
    end

    hrhp_class u_class (
        .i_byte (r_in_byte),
        .o_cls  (w_cls)
    );

    hrhp_len_track u_len (
        .i_op   (w_len_op),
        .i_byte (r_in_byte),
        .i_cls  (w_cls),
        .i_ctx  (c_len),
        .o_ctx  (n_len)
    );

    always_comb begin
        n_state    = c_state;
        n_hdr_seen = c_hdr_seen;
        n_hdr_cnt  = c_hdr_cnt;
        n_body_cnt = c_body_cnt;
        n_major    = c_major;
        n_minor    = c_minor;
        n_status   = hrhp_pkg::ST_MORE;
        n_kind     = hrhp_pkg::KIND_DELIM;
        w_len_op   = hrhp_pkg::LOP_NONE;
        w_bad      = 1'b0;
        case (c_state)
            S_METHOD_START: begin
                if (!w_cls.is_token) begin
                    w_bad = 1'b1;
                end else begin
                    n_state = S_METHOD;
                    n_kind  = hrhp_pkg::KIND_METHOD;
                end
            end
            S_METHOD: begin
                if (w_cls.is_sp) n_state = S_URI;
                else if (!w_cls.is_token) w_bad = 1'b1;
                else n_kind = hrhp_pkg::KIND_METHOD;
            end
            S_URI: begin
                if (w_cls.is_sp) n_state = S_VH;
                else if (w_cls.is_ctl) w_bad = 1'b1;
                else n_kind = hrhp_pkg::KIND_URI;
            end
            S_VH: begin
                if (r_in_byte == hrhp_pkg::CH_H) n_state = S_VT1;
                else w_bad = 1'b1;
            end
            S_VT1: begin
                if (r_in_byte == hrhp_pkg::CH_T) n_state = S_VT2;
                else w_bad = 1'b1;
            end
            S_VT2: begin
                if (r_in_byte == hrhp_pkg::CH_T) n_state = S_VP;
                else w_bad = 1'b1;
            end
            S_VP: begin
                if (r_in_byte == hrhp_pkg::CH_P) n_state = S_VSLASH;
                else w_bad = 1'b1;
            end
            S_VSLASH: begin
                if (r_in_byte == hrhp_pkg::CH_SLASH) begin
                    n_major = '0;
                    n_minor = '0;
                    n_state = S_MAJ_START;
                end else begin
                    w_bad = 1'b1;
                end
            end
            S_MAJ_START: begin
                if (w_cls.is_dec) begin
                    n_major = hrhp_pkg::dec_acc_ver(c_major, w_cls.digit);
                    n_state = S_MAJ;
                end else begin
                    w_bad = 1'b1;
                end
            end
            S_MAJ: begin
                if (r_in_byte == hrhp_pkg::CH_DOT) n_state = S_MIN_START;
                else if (w_cls.is_dec) n_major = hrhp_pkg::dec_acc_ver(c_major, w_cls.digit);
                else w_bad = 1'b1;
            end
            S_MIN_START: begin
                if (w_cls.is_dec) begin
                    n_minor = hrhp_pkg::dec_acc_ver(c_minor, w_cls.digit);
                    n_state = S_MIN;
                end else begin
                    w_bad = 1'b1;
                end
            end
            S_MIN: begin
                if (w_cls.is_cr) n_state = S_NL1;
                else if (w_cls.is_dec) n_minor = hrhp_pkg::dec_acc_ver(c_minor, w_cls.digit);
                else w_bad = 1'b1;
            end
            S_NL1: begin
                if (w_cls.is_lf) n_state = S_LINE_START;
                else w_bad = 1'b1;
            end
            S_LINE_START: begin
                if (w_cls.is_cr) begin
                    n_state = S_NL3;
                end else if (c_hdr_seen && (w_cls.is_sp || w_cls.is_tab)) begin
                    n_state = S_LWS;
                end else if (!w_cls.is_token ||
                             c_hdr_cnt >= hrhp_pkg::HDR_CNT_W'(hrhp_pkg::MAX_HEADERS)) begin
                    w_bad = 1'b1;
                end else begin
                    n_hdr_cnt  = c_hdr_cnt + 1'b1;
                    n_hdr_seen = 1'b1;
                    w_len_op   = hrhp_pkg::LOP_NAME_FIRST;
                    n_state    = S_NAME;
                    n_kind     = hrhp_pkg::KIND_HNAME;
                end
            end
            S_LWS: begin
                if (w_cls.is_cr) begin
                    n_state = S_NL2;
                end else if (w_cls.is_sp || w_cls.is_tab) begin
                    n_state = S_LWS;
                end else if (w_cls.is_ctl) begin
                    w_bad = 1'b1;
                end else begin
                    w_len_op = hrhp_pkg::LOP_VALUE;
                    n_state  = S_VALUE;
                    n_kind   = hrhp_pkg::KIND_HVALUE;
                end
            end
            S_NAME: begin
                if (r_in_byte == hrhp_pkg::CH_COLON) begin
                    w_len_op = hrhp_pkg::LOP_COLON;
                    n_state  = S_SP_VALUE;
                end else if (!w_cls.is_token) begin
                    w_bad = 1'b1;
                end else begin
                    w_len_op = hrhp_pkg::LOP_NAME_BYTE;
                    n_kind   = hrhp_pkg::KIND_HNAME;
                end
            end
            S_SP_VALUE: begin
                if (w_cls.is_sp) n_state = S_VALUE;
                else w_bad = 1'b1;
            end
            S_VALUE: begin
                if (w_cls.is_cr) begin
                    n_state = S_NL2;
                end else if (w_cls.is_ctl) begin
                    w_bad = 1'b1;
                end else begin
                    w_len_op = hrhp_pkg::LOP_VALUE;
                    n_kind   = hrhp_pkg::KIND_HVALUE;
                end
            end
            S_NL2: begin
                if (w_cls.is_lf) n_state = S_LINE_START;
                else w_bad = 1'b1;
            end
            S_NL3: begin
                // an unfinished or invalid Content-Length rejects the blank line
                if (!w_cls.is_lf || c_len.phase == hrhp_pkg::LF_LEAD ||
                    c_len.phase == hrhp_pkg::LF_PLUS || c_len.phase == hrhp_pkg::LF_BAD) begin
                    w_bad = 1'b1;
                end else begin
                    n_state = S_BODY;
                    if (hrhp_pkg::eff_length(c_len) == '0) n_status = hrhp_pkg::ST_COMPLETE;
                end
            end
            S_BODY: begin
                if (c_body_cnt != hrhp_pkg::LEN_MAX) n_body_cnt = c_body_cnt + 1'b1;
                n_kind = hrhp_pkg::KIND_BODY;
                if (n_body_cnt >= hrhp_pkg::eff_length(c_len)) n_status = hrhp_pkg::ST_COMPLETE;
            end
            default: w_bad = 1'b1;
        endcase

        // a malformed byte leaves the state as it was after any restart
        if (w_bad) begin
            n_state    = c_state;
            n_hdr_seen = c_hdr_seen;
            n_hdr_cnt  = c_hdr_cnt;
            n_body_cnt = c_body_cnt;
            n_major    = c_major;
            n_minor    = c_minor;
            n_status   = hrhp_pkg::ST_MALFORMED;
            n_kind     = hrhp_pkg::KIND_DELIM;
        end
    end

    assign w_hdr_dec = n_hdr_cnt - 1'b1;

    always_comb begin
        if ((n_kind == hrhp_pkg::KIND_HNAME || n_kind == hrhp_pkg::KIND_HVALUE) &&
            n_hdr_cnt != '0) begin
            n_hnum = hrhp_pkg::HNUM_W'(w_hdr_dec);
        end else begin
            n_hnum = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_state    <= S_METHOD_START;
            r_hdr_seen <= 1'b0;
            r_hdr_cnt  <= '0;
            r_len      <= '{pos: 4'd0, still: 1'b0, phase: hrhp_pkg::LF_NONE, acc: '0};
            r_body_cnt <= '0;
            r_major    <= '0;
            r_minor    <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (i_in.valid && i_in.ready) begin
                r_in_byte    <= i_in.data_byte;
                r_in_restart <= i_in.restart;
            end
            if (w_step) begin
                r_out_vld  <= 1'b1;
                r_state    <= n_state;
                r_hdr_seen <= n_hdr_seen;
                r_hdr_cnt  <= n_hdr_cnt;
                r_len      <= w_bad ? c_len : n_len;
                r_body_cnt <= n_body_cnt;
                r_major    <= n_major;
                r_minor    <= n_minor;
                r_status   <= n_status;
                r_kind     <= n_kind;
                r_byte_out <= r_in_byte;
                r_hnum     <= n_hnum;
                r_length   <= hrhp_pkg::eff_length(w_bad ? c_len : n_len);
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.status        = r_status;
    assign o_out.byte_kind     = r_kind;
    assign o_out.byte_out      = r_byte_out;
    assign o_out.header_number = r_hnum;
    assign o_out.version_major = r_major;
    assign o_out.version_minor = r_minor;
    assign o_out.body_length   = r_length;

    `HRHP_ASSERT_IMP(a_bad_is_delim, i_clk, i_rst_n,
        r_out_vld && r_status == hrhp_pkg::ST_MALFORMED, r_kind == hrhp_pkg::KIND_DELIM)
    `HRHP_ASSERT_NXT(a_bad_holds_state, i_clk, i_rst_n,
        w_step && w_bad && !r_in_restart, $stable(r_state) && $stable(r_hdr_cnt))
    `HRHP_ASSERT_IMP(a_hdr_cnt_max, i_clk, i_rst_n,
        r_hdr_seen || !r_hdr_seen, r_hdr_cnt <= hrhp_pkg::HDR_CNT_W'(hrhp_pkg::MAX_HEADERS))
    `HRHP_ASSERT_IMP(a_body_len_valid, i_clk, i_rst_n,
        r_state == S_BODY, r_len.phase != hrhp_pkg::LF_LEAD &&
        r_len.phase != hrhp_pkg::LF_PLUS && r_len.phase != hrhp_pkg::LF_BAD)

endmodule

>>> design/hrhp_class.sv
module hrhp_class (
    input  logic [7:0]            i_byte,
    output hrhp_pkg::t_byte_class o_cls
);
    logic w_tsp;
    logic w_ctl;

    always_comb begin
        case (i_byte)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/",
            "[", "]", "?", "=", "{", "}", hrhp_pkg::CH_SP, hrhp_pkg::CH_TAB: w_tsp = 1'b1;
            default: w_tsp = 1'b0;
        endcase
    end

    assign w_ctl = (i_byte <= 8'd31) || (i_byte == 8'd127);

    always_comb begin
        o_cls.is_ctl   = w_ctl;
        o_cls.is_token = !i_byte[7] && !w_ctl && !w_tsp;
        o_cls.is_dec   = (i_byte >= hrhp_pkg::CH_ZERO) && (i_byte <= "9");
        o_cls.digit    = 4'(i_byte - hrhp_pkg::CH_ZERO);
        o_cls.is_sp    = (i_byte == hrhp_pkg::CH_SP);
        o_cls.is_tab   = (i_byte == hrhp_pkg::CH_TAB);
        o_cls.is_cr    = (i_byte == hrhp_pkg::CH_CR);
        o_cls.is_lf    = (i_byte == hrhp_pkg::CH_LF);
        o_cls.is_plus  = (i_byte == hrhp_pkg::CH_PLUS);
    end
endmodule

>>> design/hrhp_len_track.sv
module hrhp_len_track (
    input  hrhp_pkg::t_len_op     i_op,
    input  logic [7:0]            i_byte,
    input  hrhp_pkg::t_byte_class i_cls,
    input  hrhp_pkg::t_len_ctx    i_ctx,
    output hrhp_pkg::t_len_ctx    o_ctx
);
    logic w_char_hit;

    // name matcher advances only while every byte so far matched
    assign w_char_hit = (i_ctx.pos < 4'(hrhp_pkg::NAME_LEN)) &&
                        (i_byte == hrhp_pkg::name_char(i_ctx.pos));

    always_comb begin
        o_ctx = i_ctx;
        case (i_op)
            hrhp_pkg::LOP_NAME_FIRST: begin
                o_ctx.still = (i_byte == hrhp_pkg::name_char(4'd0));
                o_ctx.pos   = o_ctx.still ? 4'd1 : 4'd0;
            end
            hrhp_pkg::LOP_NAME_BYTE: begin
                if (i_ctx.still && w_char_hit) begin
                    o_ctx.pos = i_ctx.pos + 4'd1;
                end else begin
                    o_ctx.still = 1'b0;
                end
            end
            hrhp_pkg::LOP_COLON: begin
                if (i_ctx.still && i_ctx.pos == 4'(hrhp_pkg::NAME_LEN)) begin
                    o_ctx.acc   = '0;
                    o_ctx.phase = hrhp_pkg::LF_LEAD;
                end else begin
                    o_ctx.still = 1'b0;
                end
            end
            hrhp_pkg::LOP_VALUE: begin
                if (i_ctx.still) begin
                    case (i_ctx.phase)
                        hrhp_pkg::LF_LEAD, hrhp_pkg::LF_PLUS: begin
                            if (i_ctx.phase == hrhp_pkg::LF_LEAD && i_cls.is_sp) begin
                                o_ctx.phase = hrhp_pkg::LF_LEAD;
                            end else if (i_ctx.phase == hrhp_pkg::LF_LEAD && i_cls.is_plus) begin
                                o_ctx.phase = hrhp_pkg::LF_PLUS;
                            end else if (i_cls.is_dec) begin
                                o_ctx.acc   = hrhp_pkg::LEN_W'(i_cls.digit);
                                o_ctx.phase = hrhp_pkg::LF_DIGITS;
                            end else begin
                                o_ctx.phase = hrhp_pkg::LF_BAD;
                            end
                        end
                        hrhp_pkg::LF_DIGITS: begin
                            if (i_cls.is_dec) begin
                                o_ctx.acc = hrhp_pkg::dec_acc_len(i_ctx.acc, i_cls.digit);
                            end else begin
                                o_ctx.phase = hrhp_pkg::LF_DONE;
                            end
                        end
                        default: o_ctx.phase = i_ctx.phase;
                    endcase
                end
            end
            default: o_ctx = i_ctx;
        endcase
    end
endmodule
